// File: rtl/b64u_pkg.sv
`default_nettype none

package b64u_pkg;

  // Longest message in characters before status reports too long
  localparam int unsigned MaxCharsDefault = 65536;

  // Field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 16;
  localparam int unsigned SymW    = 7;

  // Packed result word: data_byte, status, decoded_length, zero fill
  localparam int unsigned OutFieldW = ByteW + StatusW + LenW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Symbol codes beyond the 6-bit alphabet
  localparam logic [SymW-1:0] SymPad = 7'd64;
  localparam logic [SymW-1:0] SymBad = 7'd65;

  // Status codes at the end of a message
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_CHAR = 2'd3
  } status_t;

  // One result word
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             byte_valid;
    logic             done_res;
    status_t          status;
    logic [LenW-1:0]  decoded_length;
  } result_t;

  // Map a character to its 6-bit value, the pad code or the bad code
  function automatic logic [SymW-1:0] sym_value(input logic [CharW-1:0] c);
    logic [SymW-1:0] v;
    if (c >= "A" && c <= "Z") begin
      v = SymW'(c - 8'd65);
    end else if (c >= "a" && c <= "z") begin
      v = SymW'(c - 8'd97 + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      v = SymW'(c - 8'd48 + 8'd52);
    end else if (c == "-") begin
      v = 7'd62;
    end else if (c == "_") begin
      v = 7'd63;
    end else if (c == "=") begin
      v = SymPad;
    end else begin
      v = SymBad;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/base64url_stream_decoder.sv
`default_nettype none

// Channel  Dir  Ports                      Contents
// -------  ---  -------------------------  ----------------------------------------
// in_      in   tvalid tready tdata tlast  one base64url character, last of message
// out_     out  tvalid tready tdata tuser  decoded byte and/or end-of-message report
//                 tlast
//
// One input word is taken per cycle while in_tready is high; its result is registered
// in the output or skid register. The decode state (bit accumulator, pad and length
// counters) is updated in the same cycle the word is accepted.
// Reset (rst_n low, synchronous) clears all decode state and the output stage valid flags.
// A two-entry output stage (output register plus skid register) lets input run
// while a result waits; in_tready drops only when both entries are full.
module base64url_stream_decoder #(
  parameter int unsigned MAX_CHARS = b64u_pkg::MaxCharsDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [b64u_pkg::CharW-1:0]  in_tdata,   // [7:0] in_char
  input  wire logic                        in_tlast,   // last
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [b64u_pkg::OutDataW-1:0]    out_tdata,  // [7:0] data_byte, [9:8] status,
                                                       // [25:10] decoded_length, rest 0
  output logic                             out_tuser,  // byte_valid
  output logic                             out_tlast   // done_res
);
  import b64u_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CHARS + 2);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CHARS);

  // Decode state
  logic [5:0]      res_bits_r, res_bits_nxt;
  logic [2:0]      res_cnt_r, res_cnt_nxt;
  logic [1:0]      pads_r, pads_nxt;
  logic [CntW-1:0] char_cnt_r, char_cnt_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic            err_r, err_nxt;

  // Output stage
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  logic            in_acc;
  logic [SymW-1:0] sym;
  logic            too_long;
  logic [11:0]     acc;
  logic [3:0]      nbits;
  logic [3:0]      nleft;
  logic            have_byte;
  logic [7:0]      byte_val;
  logic [1:0]      total_mod;
  logic [CntW-1:0] dcnt;
  logic [CntW-1:0] dquad;
  logic [LenW-1:0] len;
  status_t         st;
  result_t         res;
  logic            res_valid;
  logic            out_load;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign sym       = sym_value(in_tdata);

  // Compute next decode state and the result for the incoming word
  always_comb begin
    res_bits_nxt = res_bits_r;
    res_cnt_nxt  = res_cnt_r;
    pads_nxt     = pads_r;
    phase_nxt    = phase_r;
    err_nxt      = err_r;
    have_byte    = 1'b0;
    byte_val     = '0;

    char_cnt_nxt = (char_cnt_r <= MaxCnt) ? char_cnt_r + 1'b1 : char_cnt_r;
    too_long     = char_cnt_nxt > MaxCnt;

    acc   = {res_bits_r, sym[5:0]};
    nbits = {1'b0, res_cnt_r} + 4'd6;
    nleft = (nbits >= 4'd8) ? nbits - 4'd8 : nbits;

    if (sym == SymPad) begin
      if (pads_r >= 2'd2) begin
        err_nxt   = 1'b1;
        phase_nxt = phase_r + 2'd1;
      end else begin
        pads_nxt = pads_r + 2'd1;
      end
    end else if (sym == SymBad) begin
      err_nxt   = 1'b1;
      phase_nxt = phase_r + 2'd1 + pads_r;
      pads_nxt  = '0;
    end else begin
      // Data character: a pad before it is misplaced
      if (pads_r != 2'd0) begin
        err_nxt = 1'b1;
      end
      phase_nxt = phase_r + 2'd1 + pads_r;
      pads_nxt  = '0;
      if (!err_r && pads_r == 2'd0 && !too_long) begin
        if (nbits >= 4'd8) begin
          have_byte = 1'b1;
          byte_val  = 8'(acc >> nleft);
        end
        res_cnt_nxt  = nleft[2:0];
        res_bits_nxt = acc[5:0] & ~(6'h3f << nleft);
      end
    end

    // End-of-message status and length
    total_mod = phase_nxt + pads_nxt;
    dcnt      = char_cnt_nxt - CntW'(pads_nxt);
    dquad     = dcnt >> 2;
    len       = '0;
    if (too_long) begin
      st = ST_TOO_LONG;
    end else if (char_cnt_nxt < CntW'(2) || (pads_nxt != 2'd0 && total_mod != 2'd0) ||
                 phase_nxt == 2'd1) begin
      st = ST_BAD_LEN;
    end else if (err_nxt) begin
      st = ST_BAD_CHAR;
    end else begin
      st  = ST_OK;
      len = LenW'(dquad) + LenW'({dquad, 1'b0}) +
            ((dcnt[1:0] != 2'd0) ? LenW'(dcnt[1:0] - 2'd1) : LenW'(0));
    end

    res.data_byte      = byte_val;
    res.byte_valid     = have_byte;
    res.done_res       = in_tlast;
    res.status         = in_tlast ? st : ST_OK;
    res.decoded_length = in_tlast ? len : '0;
    res_valid          = in_acc && (have_byte || in_tlast);
  end

  // Advance decode state; clear it after the last word of a message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_bits_r <= '0;
      res_cnt_r  <= '0;
      pads_r     <= '0;
      char_cnt_r <= '0;
      phase_r    <= '0;
      err_r      <= 1'b0;
    end else if (in_acc) begin
      if (in_tlast) begin
        res_bits_r <= '0;
        res_cnt_r  <= '0;
        pads_r     <= '0;
        char_cnt_r <= '0;
        phase_r    <= '0;
        err_r      <= 1'b0;
      end else begin
        res_bits_r <= res_bits_nxt;
        res_cnt_r  <= res_cnt_nxt;
        pads_r     <= pads_nxt;
        char_cnt_r <= char_cnt_nxt;
        phase_r    <= phase_nxt;
        err_r      <= err_nxt;
      end
    end
  end

  // Output register with skid: refill from skid first, else from the new word
  assign out_load = out_tready || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Hold payload words; no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_load && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.byte_valid;
  assign out_tlast  = out_r.done_res;
  assign out_tdata  = OutDataW'({out_r.decoded_length, out_r.status, out_r.data_byte});

endmodule

`default_nettype wire

// File: sim/base64url_stream_decoder_tb.sv
module base64url_stream_decoder_tb;
  import b64u_pkg::*;

  localparam int unsigned MaxChars   = MaxCharsDefault;
  localparam int unsigned RandWords  = 1850;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned TailCycles = 8;
  localparam logic [7:0]  PadChar    = "=";

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_FIXED,
    ROW_NONE
  } row_kind_t;

  typedef struct {
    logic [7:0] ch;
    bit         last;
    row_kind_t  kind;
    result_t    fixed;
  } stim_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [CharW-1:0]    in_tdata   = '0;
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  // Decoder shadow state
  logic [5:0]  acc_bits;
  logic [2:0]  acc_cnt;
  logic [1:0]  pad_run;
  logic [16:0] char_cnt;
  logic [1:0]  phase;
  bit          bad_seen;

  result_t         pending_results[$];
  stim_row_t       stim_rows[$];
  logic [7:0]      msg_text[$];
  int unsigned     mismatch_cnt = 0;
  int unsigned     idle_cycles  = 0;
  int unsigned     rand_words   = 0;
  int unsigned     stall_left   = 0;
  bit              tx_calm      = 1'b0;
  bit              rx_calm      = 1'b0;

  base64url_stream_decoder #(
    .MAX_CHARS(MaxChars)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Character to 6-bit value, pad code or bad code
  function automatic logic [6:0] char_to_sym(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
    if (c == "-") return 7'd62;
    if (c == "_") return 7'd63;
    if (c == PadChar) return SymPad;
    return SymBad;
  endfunction

  function automatic logic [7:0] alpha_char(input int unsigned idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    return (idx == 62) ? "-" : "_";
  endfunction

  // Mostly alphabet, some pads, some arbitrary bytes
  function automatic logic [7:0] noise_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return alpha_char($urandom_range(0, 63));
    if (r < 80) return PadChar;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic result_t mk_result(input logic [7:0] b, input bit valid, input bit done,
                                        input status_t st, input logic [15:0] len);
    result_t r;
    r.data_byte      = b;
    r.byte_valid     = valid;
    r.done_res       = done;
    r.status         = st;
    r.decoded_length = len;
    return r;
  endfunction

  task automatic clear_decoder();
    acc_bits = '0;
    acc_cnt  = '0;
    pad_run  = '0;
    char_cnt = '0;
    phase    = '0;
    bad_seen = 1'b0;
  endtask

  // Advance the shadow decoder by one character; report the result it yields
  task automatic decode_step(input logic [7:0] ch, input bit last,
                             output bit have, output result_t res);
    logic [6:0]  sym;
    logic [11:0] acc;
    int unsigned n;
    bit          over;
    logic [1:0]  total_mod;
    logic [16:0] d;
    res  = '0;
    have = 1'b0;
    sym  = char_to_sym(ch);
    if (char_cnt <= MaxChars) char_cnt = char_cnt + 17'd1;
    over = char_cnt > MaxChars;

    if (sym == SymPad) begin
      // A third pad in a row is an error and counts as data
      if (pad_run == 2'd2) begin
        bad_seen = 1'b1;
        phase    = phase + 2'd1;
      end else begin
        pad_run = pad_run + 2'd1;
      end
    end else begin
      // Pads before a data char turn into data chars
      if (sym == SymBad || pad_run != 2'd0) bad_seen = 1'b1;
      phase   = phase + 2'd1 + pad_run;
      pad_run = 2'd0;
      if (sym != SymBad && !bad_seen && !over) begin
        acc = {acc_bits, sym[5:0]};
        n   = acc_cnt + 6;
        if (n >= 8) begin
          n             = n - 8;
          res.data_byte = 8'(acc >> n);
          have          = 1'b1;
        end
        acc_cnt  = 3'(n);
        acc_bits = 6'(acc & ((12'd1 << n) - 12'd1));
      end
    end
    res.byte_valid = have;

    // Close the message: status by priority, then length
    if (last) begin
      total_mod    = phase + pad_run;
      res.done_res = 1'b1;
      have         = 1'b1;
      if (over) begin
        res.status = ST_TOO_LONG;
      end else if (char_cnt < 2 || (pad_run != 2'd0 && total_mod != 2'd0) ||
                   phase == 2'd1) begin
        res.status = ST_BAD_LEN;
      end else if (bad_seen) begin
        res.status = ST_BAD_CHAR;
      end else begin
        d = char_cnt - pad_run;
        res.decoded_length = 16'((d >> 2) * 3 + ((d[1:0] != 2'd0) ? d[1:0] - 1 : 0));
      end
      clear_decoder();
    end
  endtask

  // Drive one word; record what it should produce once accepted
  task automatic send_char(input logic [7:0] ch, input bit last, input row_kind_t kind,
                           input result_t typed);
    int unsigned gap;
    bit          have;
    result_t     res;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = ch;
    in_tlast  = last;
    do @(posedge clk); while (in_tready !== 1'b1);
    decode_step(ch, last, have, res);
    if (kind == ROW_FIXED) begin
      pending_results.push_back(typed);
    end else if (kind == ROW_PRED && have) begin
      pending_results.push_back(res);
    end
    @(negedge clk);
  endtask

  task automatic send_text();
    tx_calm = ($urandom_range(0, 3) == 0);
    foreach (msg_text[i]) begin
      send_char(msg_text[i], i == msg_text.size() - 1, ROW_PRED, '0);
    end
  endtask

  // Well-formed text, text with one char spoiled, or plain noise
  task automatic build_random_msg();
    int unsigned kind;
    int unsigned dlen;
    int unsigned npad;
    int unsigned spot;
    msg_text.delete();
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      do begin
        dlen = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 120) : $urandom_range(2, 16);
      end while (dlen % 4 == 1);
      npad = 0;
      if (dlen % 4 == 2 && $urandom_range(0, 1) == 1) npad = 2;
      if (dlen % 4 == 3 && $urandom_range(0, 1) == 1) npad = 1;
      repeat (dlen) msg_text.push_back(alpha_char($urandom_range(0, 63)));
      repeat (npad) msg_text.push_back(PadChar);
      if (kind >= 60) begin
        spot           = $urandom_range(0, msg_text.size() - 1);
        msg_text[spot] = noise_char();
      end
    end else begin
      repeat ($urandom_range(1, 12)) msg_text.push_back(noise_char());
    end
  endtask

  task automatic add_row(input logic [7:0] ch, input bit last, input row_kind_t kind,
                         input result_t fixed);
    stim_row_t row;
    row.ch    = ch;
    row.last  = last;
    row.kind  = kind;
    row.fixed = fixed;
    stim_rows.push_back(row);
  endtask

  // Result side: random stalls, with calm stretches
  always @(negedge clk) begin
    int unsigned pick;
    if ($urandom_range(0, 199) == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (stall_left != 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      if (!rx_calm) begin
        pick = $urandom_range(0, 99);
        if (pick >= 95) begin
          stall_left = $urandom_range(5, 30);
        end else if (pick >= 70) begin
          stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = mk_result(out_tdata[7:0], out_tuser, out_tlast, status_t'(out_tdata[9:8]),
                       out_tdata[25:10]);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected word: byte %02h valid %0d done %0d status %0d len %0d",
                   seen.data_byte, seen.byte_valid, seen.done_res, seen.status,
                   seen.decoded_length);
        end
      end else begin
        want = pending_results.pop_front();
        if (seen.data_byte !== want.data_byte || seen.byte_valid !== want.byte_valid ||
            seen.done_res !== want.done_res || seen.status !== want.status ||
            seen.decoded_length !== want.decoded_length) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected byte %02h valid %0d done %0d status %0d len %0d",
                     want.data_byte, want.byte_valid, want.done_res, want.status,
                     want.decoded_length);
            $display("          actual   byte %02h valid %0d done %0d status %0d len %0d",
                     seen.data_byte, seen.byte_valid, seen.done_res, seen.status,
                     seen.decoded_length);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    clear_decoder();

    // Directed cases: single char, extremes, pads, bad chars, misplaced pads
    add_row("A", 1'b1, ROW_FIXED, mk_result(8'h00, 1'b0, 1'b1, ST_BAD_LEN, 16'd0));
    add_row("_", 1'b0, ROW_NONE, '0);
    add_row("_", 1'b1, ROW_FIXED, mk_result(8'hff, 1'b1, 1'b1, ST_OK, 16'd1));
    add_row("A", 1'b0, ROW_NONE, '0);
    add_row("A", 1'b0, ROW_FIXED, mk_result(8'h00, 1'b1, 1'b0, ST_OK, 16'd0));
    add_row(PadChar, 1'b0, ROW_NONE, '0);
    add_row(PadChar, 1'b1, ROW_FIXED, mk_result(8'h00, 1'b0, 1'b1, ST_OK, 16'd1));
    add_row("A", 1'b0, ROW_PRED, '0);
    add_row(8'h00, 1'b1, ROW_FIXED, mk_result(8'h00, 1'b0, 1'b1, ST_BAD_CHAR, 16'd0));
    add_row("z", 1'b0, ROW_PRED, '0);
    add_row(8'hff, 1'b0, ROW_PRED, '0);
    add_row("9", 1'b1, ROW_PRED, '0);
    add_row("A", 1'b0, ROW_PRED, '0);
    add_row("B", 1'b0, ROW_PRED, '0);
    add_row(PadChar, 1'b0, ROW_PRED, '0);
    add_row("C", 1'b1, ROW_PRED, '0);
    add_row("A", 1'b0, ROW_PRED, '0);
    add_row("A", 1'b0, ROW_PRED, '0);
    add_row(PadChar, 1'b0, ROW_PRED, '0);
    add_row(PadChar, 1'b0, ROW_PRED, '0);
    add_row(PadChar, 1'b1, ROW_PRED, '0);
    add_row("-", 1'b0, ROW_PRED, '0);
    add_row("0", 1'b0, ROW_PRED, '0);
    add_row("a", 1'b0, ROW_PRED, '0);
    add_row(PadChar, 1'b1, ROW_PRED, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      send_char(stim_rows[i].ch, stim_rows[i].last, stim_rows[i].kind, stim_rows[i].fixed);
    end

    while (rand_words < RandWords) begin
      build_random_msg();
      rand_words += msg_text.size();
      send_text();
    end
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;

    // Drain, then allow for the output latency
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/b64u_pkg.sv
rtl/base64url_stream_decoder.sv
sim/base64url_stream_decoder_tb.sv
